/* rtl/tftp_pp_pkg.sv */
// Shared types and constants for the TFTP packet parser.
`timescale 1ns / 1ps

package tftp_pp_pkg;

  // Widths of the fields in one result item.
  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;
  localparam int NUM_W  = 16;
  localparam int SIZE_W = 10;
  localparam int CNT_W  = 10;

  // Default field limits.
  localparam int NAME_LIMIT_DEF    = 1024;
  localparam int MODE_LIMIT_DEF    = 20;
  localparam int DATA_LIMIT_DEF    = 512;
  localparam int MESSAGE_LIMIT_DEF = 1024;

  // Result queue geometry. The depth must be a power of two.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_NAME    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MODE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MESSAGE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd4;

  // TFTP opcodes, as carried in the status item.
  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_RRQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRQ   = 3'd2;
  localparam logic [OP_W-1:0] OP_DATA  = 3'd3;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_ERROR = 3'd5;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] out_byte;
    logic              packet_end;
    logic              valid_res;
    logic [OP_W-1:0]   opcode;
    logic [NUM_W-1:0]  number;
    logic [SIZE_W-1:0] data_size;
  } tpp_item_t;

  // Up to two results produced by one accepted byte: payload first, then status.
  typedef struct packed {
    logic      pay_vld;
    logic      sts_vld;
    tpp_item_t pay;
    tpp_item_t sts;
  } tpp_push_t;

endpackage

/* rtl/tftp_packet_parser.sv */
// Top level of the TFTP packet parser.
`timescale 1ns / 1ps

// Takes one datagram byte per request, in order, with in_last_byte set on the
// final byte, and accepts a byte every cycle while in_stall is low. Each byte
// is parsed in the cycle it is accepted and its results are written into a
// four-entry result queue, from which the out_ channel offers them in order.
// A byte gives at most one payload result, and its final byte also gives a
// status result, so a packet of N bytes yields up to N+1 results; the output
// sends one result per cycle while out_stall is low, and in_stall rises only
// while the queue holds more than two results. Status fields are zero on
// payload results, and payload results already sent stay sent when the
// closing status says the packet is invalid.
module tftp_packet_parser import tftp_pp_pkg::*; #(
  parameter int NAME_LIMIT    = NAME_LIMIT_DEF,
  parameter int MODE_LIMIT    = MODE_LIMIT_DEF,
  parameter int DATA_LIMIT    = DATA_LIMIT_DEF,
  parameter int MESSAGE_LIMIT = MESSAGE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_out_byte,
  output logic              out_packet_end,
  output logic              out_valid_res,
  output logic [OP_W-1:0]   out_opcode,
  output logic [NUM_W-1:0]  out_number,
  output logic [SIZE_W-1:0] out_data_size
);

  tpp_push_t push;
  tpp_item_t head;
  logic      room;
  logic      accept;

  // Input handshake.
  assign in_stall = !room;
  assign accept   = in_valid && room;

  tftp_pp_parse #(
    .NAME_LIMIT    (NAME_LIMIT),
    .MODE_LIMIT    (MODE_LIMIT),
    .DATA_LIMIT    (DATA_LIMIT),
    .MESSAGE_LIMIT (MESSAGE_LIMIT)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (push)
  );

  tftp_pp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .pop      (!out_stall),
    .head_vld (out_valid),
    .head     (head)
  );

  // Result fields.
  assign out_kind       = head.kind;
  assign out_out_byte   = head.out_byte;
  assign out_packet_end = head.packet_end;
  assign out_valid_res  = head.valid_res;
  assign out_opcode     = head.opcode;
  assign out_number     = head.number;
  assign out_data_size  = head.data_size;

endmodule

/* rtl/tftp_pp_parse.sv */
// Byte-at-a-time TFTP header and field parser.
`timescale 1ns / 1ps

module tftp_pp_parse import tftp_pp_pkg::*; #(
  parameter int NAME_LIMIT    = NAME_LIMIT_DEF,
  parameter int MODE_LIMIT    = MODE_LIMIT_DEF,
  parameter int DATA_LIMIT    = DATA_LIMIT_DEF,
  parameter int MESSAGE_LIMIT = MESSAGE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  output tpp_push_t         push
);

  // Parse phases.
  localparam logic [2:0] PH_OP_HI  = 3'd0;
  localparam logic [2:0] PH_OP_LO  = 3'd1;
  localparam logic [2:0] PH_NUM_HI = 3'd2;
  localparam logic [2:0] PH_NUM_LO = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;
  localparam logic [2:0] PH_NAME   = 3'd5;
  localparam logic [2:0] PH_MODE   = 3'd6;
  localparam logic [2:0] PH_SKIP   = 3'd7;

  localparam logic [CNT_W-1:0] NAME_MAX = CNT_W'(NAME_LIMIT - 1);
  localparam logic [CNT_W-1:0] MODE_MAX = CNT_W'(MODE_LIMIT - 1);
  localparam logic [CNT_W-1:0] DATA_MAX = CNT_W'(DATA_LIMIT);
  localparam logic [CNT_W-1:0] MSG_MAX  = CNT_W'(MESSAGE_LIMIT - 1);

  logic [2:0]        phase_r, phase_nxt;
  logic [7:0]        op_hi_r, op_hi_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              bad_r, bad_nxt;
  logic              ok;
  logic              pay_vld;
  logic [KIND_W-1:0] pay_kind;
  logic [BYTE_W-1:0] pay_byte;
  logic [15:0]       op_word;
  logic              good;

  assign op_word = {op_hi_r, data_byte};

  // Next state and payload for the byte on the input.
  always_comb begin
    phase_nxt = phase_r;
    op_hi_nxt = op_hi_r;
    op_nxt    = op_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    bad_nxt   = bad_r;
    ok        = 1'b0;
    pay_vld   = 1'b0;
    pay_kind  = KIND_NAME;
    pay_byte  = data_byte;
    unique case (phase_r)
      PH_OP_HI: begin
        op_hi_nxt = data_byte;
        phase_nxt = PH_OP_LO;
      end
      PH_OP_LO: begin
        cnt_nxt = '0;
        if (op_word == 16'(OP_RRQ) || op_word == 16'(OP_WRQ)) begin
          op_nxt    = op_word[OP_W-1:0];
          phase_nxt = PH_NAME;
        end else if (op_word == 16'(OP_DATA) || op_word == 16'(OP_ACK) ||
                     op_word == 16'(OP_ERROR)) begin
          op_nxt    = op_word[OP_W-1:0];
          phase_nxt = PH_NUM_HI;
        end else begin
          op_nxt    = OP_NONE;
          bad_nxt   = 1'b1;
          phase_nxt = PH_SKIP;
        end
      end
      PH_NUM_HI: begin
        num_nxt   = {data_byte, 8'h00};
        phase_nxt = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        num_nxt   = {num_r[15:8], data_byte};
        phase_nxt = PH_BODY;
        cnt_nxt   = '0;
        ok        = (op_r == OP_DATA) || (op_r == OP_ACK);
      end
      PH_BODY: begin
        if (op_r == OP_DATA) begin
          if (cnt_r < DATA_MAX) begin
            pay_vld  = 1'b1;
            pay_kind = KIND_DATA;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
          ok = 1'b1;
        end else if (op_r == OP_ERROR) begin
          if (last_byte) begin
            ok = (data_byte == 8'h00);
          end else if (cnt_r < MSG_MAX) begin
            pay_vld  = 1'b1;
            pay_kind = KIND_MESSAGE;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end else begin
          ok = 1'b1;
        end
      end
      PH_NAME: begin
        if (data_byte == 8'h00) begin
          phase_nxt = PH_MODE;
          cnt_nxt   = '0;
        end else if (cnt_r < NAME_MAX) begin
          pay_vld  = 1'b1;
          pay_kind = KIND_NAME;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      PH_MODE: begin
        if (data_byte == 8'h00) begin
          phase_nxt = PH_SKIP;
          ok        = 1'b1;
        end else if (cnt_r < MODE_MAX) begin
          pay_vld  = 1'b1;
          pay_kind = KIND_MODE;
          cnt_nxt  = cnt_r + 1'b1;
          // Upper-case letters fold to lower case.
          if (data_byte >= 8'h41 && data_byte <= 8'h5A) begin
            pay_byte = data_byte | 8'h20;
          end
        end
      end
      PH_SKIP: begin
        ok = (op_r == OP_RRQ) || (op_r == OP_WRQ);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign good = ok && !bad_nxt;

  // Results handed to the queue; nothing is produced without an accepted byte.
  always_comb begin
    push.pay_vld        = accept && pay_vld;
    push.pay.kind       = pay_kind;
    push.pay.out_byte   = pay_byte;
    push.pay.packet_end = 1'b0;
    push.pay.valid_res  = 1'b0;
    push.pay.opcode     = OP_NONE;
    push.pay.number     = '0;
    push.pay.data_size  = '0;

    push.sts_vld        = accept && last_byte;
    push.sts.kind       = KIND_STATUS;
    push.sts.out_byte   = '0;
    push.sts.packet_end = 1'b1;
    push.sts.valid_res  = good;
    push.sts.opcode     = good ? op_nxt : OP_NONE;
    push.sts.number     = (good && op_nxt >= OP_DATA) ? num_nxt : '0;
    push.sts.data_size  = (good && op_nxt == OP_DATA) ? SIZE_W'(cnt_nxt) : '0;
  end

  // Parser state; a final byte returns everything to the reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r <= PH_OP_HI;
      op_hi_r <= '0;
      op_r    <= OP_NONE;
      num_r   <= '0;
      cnt_r   <= '0;
      bad_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      op_hi_r <= op_hi_nxt;
      op_r    <= op_nxt;
      num_r   <= num_nxt;
      cnt_r   <= cnt_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // A packet always starts over at the opcode after its final byte.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> (phase_r == PH_OP_HI && !bad_r && cnt_r == '0))
    else $error("parser did not restart after the final byte");

  // An invalid status carries no opcode, number or size.
  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (push.sts_vld && !push.sts.valid_res) |->
      (push.sts.opcode == OP_NONE && push.sts.number == '0 &&
       push.sts.data_size == '0))
    else $error("invalid status carries nonzero fields");

  // Once a packet is marked bad it stays bad until its final byte.
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (bad_r && !(accept && last_byte)) |=> bad_r)
    else $error("bad packet flag cleared mid-packet");

endmodule

/* rtl/tftp_pp_queue.sv */
// Small result queue that takes up to two items per cycle and sends one per cycle when popped.
`timescale 1ns / 1ps

module tftp_pp_queue import tftp_pp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tpp_push_t push,
  output logic      room,
  input  logic      pop,
  output logic      head_vld,
  output tpp_item_t head
);

  tpp_item_t           q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic [Q_PTR_W-1:0]  sts_idx;
  logic                do_pop;

  // Room for the two results that a single byte can produce.
  assign room     = (count_r <= Q_CNT_W'(Q_DEPTH - 2));
  assign head_vld = (count_r != '0);
  assign head     = q_r[rd_ptr_r];
  assign do_pop   = pop && head_vld;

  // The status item lands right after the payload item when both are present.
  assign sts_idx    = wr_ptr_r + Q_PTR_W'(push.pay_vld);
  assign wr_ptr_nxt = sts_idx + Q_PTR_W'(push.sts_vld);
  assign rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(do_pop);
  assign count_nxt  = count_r + Q_CNT_W'(push.pay_vld) + Q_CNT_W'(push.sts_vld)
                      - Q_CNT_W'(do_pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.pay_vld) begin
      q_r[wr_ptr_r] <= push.pay;
    end
    if (push.sts_vld) begin
      q_r[sts_idx] <= push.sts;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The fill level never passes the depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // The fill level tracks the pointer distance.
  a_level_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(count_r) == Q_PTR_W'(wr_ptr_r - rd_ptr_r)))
    else $error("queue level out of step with pointers");

  // A final byte with payload adds two entries when nothing leaves.
  a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push.pay_vld && push.sts_vld && !do_pop) |=>
      (count_r == $past(count_r) + Q_CNT_W'(2)))
    else $error("double push lost an entry");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the TFTP packet parser, fed one datagram byte per request.
`timescale 1ns / 1ps

module tb_top;
  import tftp_pp_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_CYC   = 11;
  localparam int RANDOM_BYTES = 600;
  localparam int TAIL_BYTES  = 150;
  localparam int DRAIN_CYC   = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP   = 40;

  // Parser phases, tracked by the predictor.
  typedef enum logic [2:0] {
    ST_OPC_HI, ST_OPC_LO, ST_NUM_HI, ST_NUM_LO, ST_BODY, ST_NAME, ST_MODE, ST_DRAIN
  } parse_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } dgram_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [BYTE_W-1:0] out_out_byte;
  logic              out_packet_end;
  logic              out_valid_res;
  logic [OP_W-1:0]   out_opcode;
  logic [NUM_W-1:0]  out_number;
  logic [SIZE_W-1:0] out_data_size;

  // Stimulus and expectation stores.
  dgram_byte_t       dgram_bytes[$];
  logic [7:0]        pkt[$];
  tpp_item_t         expected_items[$];

  int                errors = 0;
  int                result_idx = 0;
  int                cycles = 0;
  int                random_bytes = 0;
  logic              idle_ok = 1'b0;
  logic              calm = 1'b0;

  // Predictor state.
  parse_state_e      pr_state = ST_OPC_HI;
  logic [15:0]       pr_opcode = '0;
  logic [15:0]       pr_number = '0;
  int                pr_count = 0;
  logic              pr_bad = 1'b0;

  tftp_packet_parser i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_packet_end (out_packet_end),
    .out_valid_res  (out_valid_res),
    .out_opcode     (out_opcode),
    .out_number     (out_number),
    .out_data_size  (out_data_size)
  );

  always #CLK_HALF clk = ~clk;

  function automatic tpp_item_t payload(input logic [KIND_W-1:0] k, input logic [7:0] v);
    tpp_item_t p;
    p = '0;
    p.kind = k;
    p.out_byte = v;
    return p;
  endfunction

  // Work out the results that one accepted datagram byte causes.
  function automatic void parse_expected(input logic [7:0] b, input logic last);
    logic      ok;
    logic      is_req;
    tpp_item_t sts;
    ok = 1'b0;
    is_req = (pr_opcode == 16'(OP_RRQ)) || (pr_opcode == 16'(OP_WRQ));
    case (pr_state)
      ST_OPC_HI: begin
        pr_opcode = {b, 8'h00};
        pr_state = ST_OPC_LO;
      end
      ST_OPC_LO: begin
        pr_opcode[7:0] = b;
        pr_count = 0;
        if (pr_opcode == 16'(OP_RRQ) || pr_opcode == 16'(OP_WRQ)) begin
          pr_state = ST_NAME;
        end else if (pr_opcode >= 16'(OP_DATA) && pr_opcode <= 16'(OP_ERROR)) begin
          pr_state = ST_NUM_HI;
        end else begin
          pr_bad = 1'b1;
          pr_state = ST_DRAIN;
        end
      end
      ST_NUM_HI: begin
        pr_number = {b, 8'h00};
        pr_state = ST_NUM_LO;
      end
      ST_NUM_LO: begin
        pr_number[7:0] = b;
        pr_state = ST_BODY;
        pr_count = 0;
        ok = (pr_opcode == 16'(OP_DATA)) || (pr_opcode == 16'(OP_ACK));
      end
      ST_BODY: begin
        if (pr_opcode == 16'(OP_DATA)) begin
          if (pr_count < DATA_LIMIT_DEF) begin
            expected_items.push_back(payload(KIND_DATA, b));
            pr_count++;
          end else begin
            pr_bad = 1'b1;
          end
          ok = 1'b1;
        end else if (pr_opcode == 16'(OP_ERROR)) begin
          // The closing byte of an error message is the terminator and is not passed on.
          if (last) begin
            ok = (b == 8'h00);
          end else if (pr_count < MESSAGE_LIMIT_DEF - 1) begin
            expected_items.push_back(payload(KIND_MESSAGE, b));
            pr_count++;
          end
        end else begin
          ok = 1'b1;
        end
      end
      ST_NAME: begin
        if (b == 8'h00) begin
          pr_state = ST_MODE;
          pr_count = 0;
        end else if (pr_count < NAME_LIMIT_DEF - 1) begin
          expected_items.push_back(payload(KIND_NAME, b));
          pr_count++;
        end
      end
      ST_MODE: begin
        if (b == 8'h00) begin
          pr_state = ST_DRAIN;
          ok = 1'b1;
        end else if (pr_count < MODE_LIMIT_DEF - 1) begin
          expected_items.push_back(payload(KIND_MODE,
            (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b));
          pr_count++;
        end
      end
      default: begin
        ok = is_req;
      end
    endcase

    // The final byte closes the packet with a status item and clears the state.
    if (last) begin
      sts = '0;
      sts.kind = KIND_STATUS;
      sts.packet_end = 1'b1;
      if (ok && !pr_bad) begin
        sts.valid_res = 1'b1;
        sts.opcode = pr_opcode[OP_W-1:0];
        sts.number = (pr_opcode >= 16'(OP_DATA)) ? pr_number : 16'h0000;
        sts.data_size = (pr_opcode == 16'(OP_DATA)) ? SIZE_W'(pr_count) : '0;
      end
      expected_items.push_back(sts);
      pr_state = ST_OPC_HI;
      pr_opcode = '0;
      pr_number = '0;
      pr_count = 0;
      pr_bad = 1'b0;
    end
  endfunction

  task report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR: result %0d: %s", result_idx, msg);
  endtask

  task check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Move the packet under construction into the byte stream, marking its final byte.
  task commit_packet();
    dgram_byte_t d;
    for (int i = 0; i < pkt.size(); i++) begin
      d.data = pkt[i];
      d.last = (i == pkt.size() - 1);
      dgram_bytes.push_back(d);
    end
    pkt.delete();
  endtask

  task add_number(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task add_random(input int n, input bit nonzero);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(nonzero ? 1 : 0, 255)));
  endtask

  // Mode strings mix letters of both cases with arbitrary nonzero bytes.
  task add_mode(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        pkt.push_back(8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25)));
      end else begin
        pkt.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  // Build one random datagram: mostly well formed, some truncated, some noise.
  task make_packet();
    int          sel;
    logic [15:0] opw;
    sel = $urandom_range(0, 19);
    if (sel < 5) begin
      add_number(sel < 3 ? 16'(OP_RRQ) : 16'(OP_WRQ));
      add_random($urandom_range(0, 12), 1'b1);
      pkt.push_back(8'h00);
      add_mode($urandom_range(0, 9) == 0 ? $urandom_range(15, 26) : $urandom_range(0, 8));
      pkt.push_back(8'h00);
      if ($urandom_range(0, 2) == 0) add_random($urandom_range(1, 3), 1'b0);
    end else if (sel < 9) begin
      add_number(16'(OP_DATA));
      add_number(16'($urandom_range(0, 65535)));
      add_random($urandom_range(0, 9) == 0 ? $urandom_range(0, 64) : $urandom_range(0, 16),
                 1'b0);
    end else if (sel < 11) begin
      add_number(16'(OP_ACK));
      add_number(16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) add_random($urandom_range(1, 3), 1'b0);
    end else if (sel < 15) begin
      add_number(16'(OP_ERROR));
      add_number(16'($urandom_range(0, 65535)));
      add_random($urandom_range(0, 14), 1'b0);
      pkt.push_back($urandom_range(0, 4) == 0 ? 8'($urandom_range(1, 255)) : 8'h00);
    end else if (sel < 17) begin
      opw = 16'($urandom_range(0, 65535));
      if (opw >= 16'(OP_NONE) && opw <= 16'(OP_ERROR) && opw != 16'(OP_NONE)) begin
        opw[15:8] = 8'($urandom_range(1, 255));
      end
      add_number(opw);
      add_random($urandom_range(0, 4), 1'b0);
    end else begin
      add_random($urandom_range(1, 6), 1'b0);
    end
    // Cut some packets short so that missing fields and terminators show up.
    if (pkt.size() > 1 && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
    end
    random_bytes += pkt.size();
    commit_packet();
  endtask

  // Idling windows: calm stretches and the tail of the run have none.
  always @(negedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    idle_ok <= !calm && (dgram_bytes.size() >= TAIL_BYTES);
    if (cycles > CYCLE_LIMIT) begin
      $display("tftp_packet_parser: mismatch");
      $finish;
    end
  end

  // Driver: present bytes from the stream, holding each until its request is taken.
  always @(posedge clk) begin
    int          gap_left;
    dgram_byte_t d;
    if (!rst_n) begin
      gap_left = 0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_expected(in_data_byte, in_last_byte);
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 6) - 1;
          in_valid <= 1'b0;
        end else if (dgram_bytes.size() > 0) begin
          d = dgram_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= d.data;
          in_last_byte <= d.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation, and stall in bursts.
  always @(posedge clk) begin
    int        stall_left;
    tpp_item_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_items.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_items.pop_front();
          check_field("kind", out_kind, want.kind);
          check_field("out_byte", out_out_byte, want.out_byte);
          check_field("packet_end", out_packet_end, want.packet_end);
          check_field("valid_res", out_valid_res, want.valid_res);
          check_field("opcode", out_opcode, want.opcode);
          check_field("number", out_number, want.number);
          check_field("data_size", out_data_size, want.data_size);
        end
        result_idx++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed packets, one long one past the data limit, then random traffic.
  initial begin
    // Single byte, then an ACK with no block number.
    pkt = '{8'h00};
    commit_packet();
    pkt = '{8'h00, 8'h04};
    commit_packet();
    // ACK with the largest block number, and an empty DATA block zero.
    pkt = '{8'h00, 8'h04, 8'hFF, 8'hFF};
    commit_packet();
    pkt = '{8'h00, 8'h03, 8'h00, 8'h00};
    commit_packet();
    // ERROR with no message byte, and an unknown opcode.
    pkt = '{8'h00, 8'h05, 8'h00, 8'h01};
    commit_packet();
    pkt = '{8'hFF, 8'hFF, 8'h12};
    commit_packet();
    // WRQ whose mode carries an uppercase letter.
    pkt = '{8'h00, 8'h02, 8'h5A, 8'h00, 8'h41, 8'h7A, 8'h00};
    commit_packet();

    // DATA just over the data limit.
    add_number(16'(OP_DATA));
    add_number(16'h0002);
    add_random(DATA_LIMIT_DEF + 3, 1'b0);
    commit_packet();

    while (random_bytes < RANDOM_BYTES) make_packet();

    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every byte is taken and every expected result has come.
    do begin
      @(negedge clk);
    end while (dgram_bytes.size() != 0 || in_valid || expected_items.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);

    if (expected_items.size() != 0) report_mismatch("expected results left over");
    if (errors == 0) begin
      $display("tftp_packet_parser: match");
    end else begin
      $display("tftp_packet_parser: mismatch");
    end
    $finish;
  end

endmodule
